/* hw/rtl/amd_trs_pkg.sv */
// Shared constants for the affine TRS decomposition core.
// No dependencies.
`default_nettype none
package amd_trs_pkg;
  localparam int unsigned InW   = 32;
  localparam int unsigned RotW  = 18;
  localparam int unsigned SclW  = 31;
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;
endpackage
`default_nettype wire

/* hw/rtl/affine_matrix_decompose_trs_core.sv */
// Top level: affine matrix to translation, quaternion and row scale.
// Depends on amd_trs_pkg, amd_trs_sqrt, amd_trs_div.
//
// Slave channel s_axis_* carries the top three matrix rows, one matrix per
// transfer; master channel m_axis_* returns one result per matrix.
// Fully pipelined: one matrix can enter every cycle while the output is not
// stalled. The chained units are: squares register, row sqrt (32 stages), row
// normalize divide (FRAC_BITS+32 stages), branch register, quaternion sqrt
// (FRAC_BITS+2 stages), component divide (2*FRAC_BITS+3 stages) and the output
// register.
// The whole pipeline advances only when the output register is empty or
// being taken; when the receiver stalls, everything holds, so nothing is
// lost or repeated. s_axis_tready follows that same advance condition.
// Reset empties all valid bits; no result is presented after reset.
`default_nettype none
module affine_matrix_decompose_trs_core
  import amd_trs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // r0c0,r0c1,r0c2,r0c3,r1c0..r1c3,r2c0..r2c3, 32 bits each
  input  wire logic [383:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // trans_x,trans_y,trans_z(32),rot_x,rot_y,rot_z,rot_w(18),
  // scale_x,scale_y,scale_z(31), zero pad
  output logic [263:0]      m_axis_tdata
);
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned RADW = 64;
  localparam int unsigned NW   = 32 + F;          // |entry| << F
  localparam int unsigned MW   = F + 2;           // normalized magnitude
  localparam int unsigned QRW  = 2 * F + 4;       // quat radicand (even-ish)
  localparam int unsigned QRE  = QRW + (QRW % 2);
  localparam int unsigned QNW  = F + 3 + F;       // component numerator
  localparam int unsigned SW   = QRE / 2 + 1;     // divisor width
  localparam int unsigned T1W  = 3 * 32 + 288;    // pass-through for stage 1
  localparam logic [63:0] FxOne = 64'd1 << F;

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [31:0] a [12];
  for (genvar i = 0; i < 12; i++) begin : g_a
    assign a[i] = s_axis_tdata[32*i +: 32];
  end

  // stage A: sums of squares, registered, then three sqrt units
  logic [RADW-1:0] ss [3];
  logic            sq_in_vld_q;
  logic [383:0]    sq_in_dat_q;
  logic [RADW-1:0] ss_q [3];
  logic            sq_vld;
  logic [31:0]     root [3];
  logic [383:0]    sq_tag [3];
  logic [31:0]     sq_root_x [3];
  for (genvar r = 0; r < 3; r++) begin : g_row
    logic [31:0] m0, m1, m2;
    logic        v_unused;
    assign m0 = a[4*r][31] ? 32'(-a[4*r])   : 32'(a[4*r]);
    assign m1 = a[4*r+1][31] ? 32'(-a[4*r+1]) : 32'(a[4*r+1]);
    assign m2 = a[4*r+2][31] ? 32'(-a[4*r+2]) : 32'(a[4*r+2]);
    assign ss[r] = 64'(m0) * 64'(m0) + 64'(m1) * 64'(m1) + 64'(m2) * 64'(m2);
    amd_trs_sqrt #(.WIDTH(RADW), .TAGW(384)) u_sq (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sq_in_vld_q),
      .rad_i(ss_q[r]), .tag_i(sq_in_dat_q),
      .valid_o(v_unused), .root_o(sq_root_x[r]), .tag_o(sq_tag[r]));
    if (r == 0) begin : g_v
      assign sq_vld = v_unused;
    end
    assign root[r] = sq_root_x[r][31] ? 32'h7FFF_FFFF :
                     (sq_root_x[r] == 32'd0 ? 32'd1 : sq_root_x[r]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_in_vld_q <= 1'b0;
    end else if (en) begin
      sq_in_vld_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_in_dat_q <= s_axis_tdata;
      for (int i = 0; i < 3; i++) begin
        ss_q[i] <= ss[i];
      end
    end
  end

  // stage B: nine normalizing divides
  logic [NW-1:0] nq [9];
  logic          nd_vld;
  logic [383:0]  nd_tag;
  logic [92:0]   nd_sc;
  logic [8:0]    sgn_q_unused;
  logic [8:0]    nd_sgn;
  for (genvar e = 0; e < 9; e++) begin : g_nd
    localparam int unsigned R = e / 3;
    localparam int unsigned C = e % 3;
    logic signed [31:0] x;
    logic [NW-1:0] num;
    assign x = sq_tag[R][32*(4*R+C) +: 32];
    assign num = NW'(x[31] ? 32'(-x) : 32'(x)) << F;
    assign sgn_q_unused[e] = x[31];
    if (e == 0) begin : g_t
      amd_trs_div #(.NW(NW), .DW(32), .TAGW(9+93+384)) u_dv (
        .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld), .num_i(num),
        .den_i(root[R]),
        .tag_i({sgn_q_unused, root[2][30:0], root[1][30:0], root[0][30:0],
                sq_tag[0]}),
        .valid_o(nd_vld), .quo_o(nq[e]), .tag_o({nd_sgn, nd_sc, nd_tag}));
    end else begin : g_n
      logic vo;
      logic tg_o;
      amd_trs_div #(.NW(NW), .DW(32), .TAGW(1)) u_dv (
        .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld), .num_i(num),
        .den_i(root[R]), .tag_i(1'b0),
        .valid_o(vo), .quo_o(nq[e]), .tag_o(tg_o));
    end
  end

  logic signed [MW:0] m [9];
  for (genvar e = 0; e < 9; e++) begin : g_m
    assign m[e] = nd_sgn[e] ? -$signed({1'b0, nq[e][MW-1:0]})
                            :  $signed({1'b0, nq[e][MW-1:0]});
  end

  // stage C: branch select and radicand, registered
  logic signed [MW+2:0] tr, vr;
  logic [1:0] br;
  logic signed [MW+2:0] n1, n2, n3;
  always_comb begin
    tr = (MW+3)'(m[0]) + (MW+3)'(m[4]) + (MW+3)'(m[8]);
    if (tr > 0) begin
      br = BR_TRACE;
      vr = tr + (MW+3)'(FxOne);
      n1 = (MW+3)'(m[7]) - (MW+3)'(m[5]);
      n2 = (MW+3)'(m[2]) - (MW+3)'(m[6]);
      n3 = (MW+3)'(m[3]) - (MW+3)'(m[1]);
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br = BR_X;
      vr = (MW+3)'(FxOne) + (MW+3)'(m[0]) - (MW+3)'(m[4]) - (MW+3)'(m[8]);
      n1 = (MW+3)'(m[7]) - (MW+3)'(m[5]);
      n2 = (MW+3)'(m[1]) + (MW+3)'(m[3]);
      n3 = (MW+3)'(m[2]) + (MW+3)'(m[6]);
    end else if (m[4] > m[8]) begin
      br = BR_Y;
      vr = (MW+3)'(FxOne) + (MW+3)'(m[4]) - (MW+3)'(m[0]) - (MW+3)'(m[8]);
      n1 = (MW+3)'(m[2]) - (MW+3)'(m[6]);
      n2 = (MW+3)'(m[1]) + (MW+3)'(m[3]);
      n3 = (MW+3)'(m[5]) + (MW+3)'(m[7]);
    end else begin
      br = BR_Z;
      vr = (MW+3)'(FxOne) + (MW+3)'(m[8]) - (MW+3)'(m[0]) - (MW+3)'(m[4]);
      n1 = (MW+3)'(m[3]) - (MW+3)'(m[1]);
      n2 = (MW+3)'(m[2]) + (MW+3)'(m[6]);
      n3 = (MW+3)'(m[5]) + (MW+3)'(m[7]);
    end
  end

  localparam int unsigned QTW = 2 + 3 * (MW + 3) + 93 + 96;
  logic           c_vld_q;
  logic [QRE-1:0] c_rad_q;
  logic [QTW-1:0] c_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= nd_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_rad_q <= vr[MW+2] ? '0 : QRE'(vr[MW+1:0]) << F;
      c_tag_q <= {br, n1, n2, n3, nd_sc,
                  nd_tag[32*11 +: 32], nd_tag[32*7 +: 32], nd_tag[32*3 +: 32]};
    end
  end

  // stage D: quaternion root
  logic           qs_vld;
  logic [QRE/2-1:0] qr;
  logic [QTW-1:0] qs_tag;
  amd_trs_sqrt #(.WIDTH(QRE), .TAGW(QTW)) u_qsq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_vld_q), .rad_i(c_rad_q),
    .tag_i(c_tag_q), .valid_o(qs_vld), .root_o(qr), .tag_o(qs_tag));

  logic [SW-1:0] sdiv;
  assign sdiv = (qr == '0) ? SW'(1) : {qr, 1'b0};
  logic signed [MW+2:0] qn [3];
  assign qn[0] = qs_tag[189+2*(MW+3) +: MW+3];
  assign qn[1] = qs_tag[189+(MW+3) +: MW+3];
  assign qn[2] = qs_tag[189 +: MW+3];

  // stage E: three component divides
  localparam int unsigned ETW = 3 + 2 + QRE/2 + 189;
  logic [QNW-1:0] cq [3];
  logic           e_vld;
  logic [ETW-1:0] e_tag;
  logic [2:0]     nsg;
  for (genvar k = 0; k < 3; k++) begin : g_cd
    logic [QNW-1:0] num;
    assign nsg[k] = qn[k][MW+2];
    assign num = QNW'(nsg[k] ? -qn[k] : qn[k]) << F;
    if (k == 0) begin : g_t
      amd_trs_div #(.NW(QNW), .DW(SW), .TAGW(ETW)) u_dv (
        .clk_i, .rst_ni, .en_i(en), .valid_i(qs_vld), .num_i(num),
        .den_i(sdiv),
        .tag_i({nsg, qs_tag[QTW-1 -: 2], qr, qs_tag[188:0]}),
        .valid_o(e_vld), .quo_o(cq[k]), .tag_o(e_tag));
    end else begin : g_n
      logic vo;
      logic to;
      amd_trs_div #(.NW(QNW), .DW(SW), .TAGW(1)) u_dv (
        .clk_i, .rst_ni, .en_i(en), .valid_i(qs_vld), .num_i(num),
        .den_i(sdiv), .tag_i(1'b0),
        .valid_o(vo), .quo_o(cq[k]), .tag_o(to));
    end
  end

  function automatic logic [RotW-1:0] sat(input logic neg, input logic [QNW-1:0] q);
    logic [QNW-1:0] c;
    logic [RotW-1:0] r;
    c = (q > QNW'(FxOne)) ? QNW'(FxOne) : q;
    r = RotW'(c);
    return neg ? -r : r;
  endfunction

  logic [2:0]      e_sg;
  logic [1:0]      e_br;
  logic [QRE/2-1:0] e_r;
  logic [RotW-1:0] own, c1, c2, c3, qx, qy, qz, qw;
  assign e_sg = e_tag[ETW-1 -: 3];
  assign e_br = e_tag[ETW-4 -: 2];
  assign e_r  = e_tag[189 +: QRE/2];
  assign own  = RotW'(e_r >> 1);
  assign c1 = sat(e_sg[0], cq[0]);
  assign c2 = sat(e_sg[1], cq[1]);
  assign c3 = sat(e_sg[2], cq[2]);
  always_comb begin
    case (e_br)
      BR_TRACE: begin qw = own; qx = c1; qy = c2; qz = c3; end
      BR_X:     begin qx = own; qw = c1; qy = c2; qz = c3; end
      BR_Y:     begin qy = own; qw = c1; qx = c2; qz = c3; end
      default:  begin qz = own; qw = c1; qx = c2; qy = c3; end
    endcase
  end

  logic [263:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= e_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {3'd0, e_tag[96 +: 93], qw, qz, qy, qx, e_tag[95:0]};
    end
  end
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[168 +: 31] != '0 && m_axis_tdata[199 +: 31] != '0
      && m_axis_tdata[230 +: 31] != '0)) else $error("zero scale");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out moved");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("ready low");
`endif
endmodule
`default_nettype wire

/* hw/rtl/amd_trs_sqrt.sv */
// Pipelined floor integer square root, one result bit per stage.
// Depends on nothing; WIDTH is the radicand width (even).
`default_nettype none
module amd_trs_sqrt #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned TAGW  = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [WIDTH-1:0]     rad_i,
  input  wire logic [TAGW-1:0]      tag_i,
  output logic                      valid_o,
  output logic [WIDTH/2-1:0]        root_o,
  output logic [TAGW-1:0]           tag_o
);
  localparam int unsigned N = WIDTH / 2;
  logic [N:1]         vld_q;
  logic [WIDTH-1:0]   rem_q [1:N];
  logic [N-1:0]       rt_q  [1:N];
  logic [TAGW-1:0]    tg_q  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic             vld_in;
    logic [WIDTH-1:0] rem_in;
    logic [N-1:0]     rt_in;
    logic [TAGW-1:0]  tg_in;
    logic [WIDTH-1:0] trial;
    logic [WIDTH-1:0] cand;
    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = rad_i;
      assign rt_in  = '0;
      assign tg_in  = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k];
      assign rem_in = rem_q[k];
      assign rt_in  = rt_q[k];
      assign tg_in  = tg_q[k];
    end
    assign cand  = WIDTH'({rt_in, 2'b01}) << (2 * (N - 1 - k));
    assign trial = rem_in - cand;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg_q[k+1] <= tg_in;
        if (rem_in >= cand) begin
          rem_q[k+1] <= trial;
          rt_q[k+1]  <= {rt_in[N-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= rem_in;
          rt_q[k+1]  <= {rt_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = rt_q[N];
  assign tag_o   = tg_q[N];
endmodule
`default_nettype wire

/* hw/rtl/amd_trs_div.sv */
// Pipelined restoring divider of an unsigned numerator by an unsigned divisor.
// One quotient bit per stage; tag rides along. No dependencies.
`default_nettype none
module amd_trs_div #(
  parameter int unsigned NW   = 48,
  parameter int unsigned DW   = 32,
  parameter int unsigned TAGW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NW-1:0]    num_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [TAGW-1:0]  tag_i,
  output logic                  valid_o,
  output logic [NW-1:0]         quo_o,
  output logic [TAGW-1:0]       tag_o
);
  logic [NW:1]       vld_q;
  logic [DW-1:0]     rem_q [1:NW];
  logic [NW-1:0]     num_q [1:NW];
  logic [DW-1:0]     den_q [1:NW];
  logic [TAGW-1:0]   tg_q  [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic            vld_in;
    logic [DW-1:0]   rem_in;
    logic [NW-1:0]   num_in;
    logic [DW-1:0]   den_in;
    logic [TAGW-1:0] tg_in;
    logic [DW:0] sh;
    logic [DW:0] df;
    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign tg_in  = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k];
      assign rem_in = rem_q[k];
      assign num_in = num_q[k];
      assign den_in = den_q[k];
      assign tg_in  = tg_q[k];
    end
    assign sh = {rem_in, num_in[NW-1]};
    assign df = sh - {1'b0, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= den_in;
        tg_q[k+1]  <= tg_in;
        if (sh >= {1'b0, den_in}) begin
          rem_q[k+1] <= df[DW-1:0];
          num_q[k+1] <= {num_in[NW-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[DW-1:0];
          num_q[k+1] <= {num_in[NW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = num_q[NW];
  assign tag_o   = tg_q[NW];
endmodule
`default_nettype wire
